### hdl/c2ws_pkg.sv
// Shared types and constants for the curvature to wheel speed pipeline.
// No dependencies; the interfaces, the top level, the divider and the testbench import this package.
`default_nettype none
package c2ws_pkg;

   // Magnitudes of num, den and |k|*radius stay below 2^56 for a fraction width of 24.
   localparam int MAG_W       = 56;
   localparam int REM_W       = MAG_W + 1;
   localparam int RATIO_W     = 32;
   localparam int RATIO_STEPS = RATIO_W;
   localparam int BRAKE_W     = 16;
   localparam int BRAKE_STEPS = BRAKE_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int MAG_OUT_W   = 15;

   localparam logic [MAG_OUT_W-1:0] SPEED_SAT = 15'h7FFF;
   localparam logic [16:0]          UNITY_Q16 = 17'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_SPEED = 3'd0,
      REG_AXIS      = 3'd1,
      REG_RADIUS    = 3'd2,
      REG_ROTATE    = 3'd3,
      REG_OVERLAY   = 3'd4
   } csr_index_type;

   // Per-item flags that ride alongside the divider.
   typedef struct packed {
      logic straight;
      logic neg;
      logic first;
      logic brake_sat;
   } tag_type;

   function automatic logic [MAG_OUT_W-1:0] sat_speed(input logic [17:0] v);
      logic [MAG_OUT_W-1:0] r;
      r = (v > 18'(SPEED_SAT)) ? SPEED_SAT : v[MAG_OUT_W-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/c2ws_if.sv
// Channel interfaces of the curvature to wheel speed block: request, response, CSR write.
// Depends on c2ws_pkg for the CSR widths.
`default_nettype none
interface c2ws_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] curvature;

   modport source (output valid, output curvature, input ready);
   modport sink   (input valid, input curvature, output ready);
endinterface

interface c2ws_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_speed;
   logic signed [15:0] right_speed;

   modport source (output valid, output left_speed, output right_speed, input ready);
   modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

interface c2ws_csr_if;
   import c2ws_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/curvature_to_wheel_speeds.sv
// Channel  | Dir | Payload                      | Handshake
// req_chan | in  | curvature (s32)              | valid/ready, beat when both high
// rsp_chan | out | left_speed, right_speed (s16)| valid/ready, beat when both high
// csr_chan | in  | index (3b), data (24b)       | valid/ready, ready always high
//
// One curvature beat per cycle unless a response stall freezes the pipeline.
// The depth comes from the 32-stage bit-per-stage ratio divider plus eight arithmetic stages.
// Reset is synchronous, clears the valid bits and sets the CSR registers to their defaults.
// A response stall freezes the pipeline only when its last stage holds an item.
// Depends on c2ws_pkg, c2ws_if and c2ws_div_pipe.
`default_nettype none
module curvature_to_wheel_speeds #(
   parameter int CURV_FRAC_BITS = 24
) (
   input  wire logic   clock,
   input  wire logic   reset,
   c2ws_req_if.sink    req_chan,
   c2ws_rsp_if.source  rsp_chan,
   c2ws_csr_if.sink    csr_chan
);
   import c2ws_pkg::*;

   localparam longint unsigned STRAIGHT_LIMIT =
      ((64'd1 << CURV_FRAC_BITS) + 64'd999999) / 64'd1000000;
   localparam logic signed [MAG_W:0] UNIT_FIX  = {{MAG_W{1'b0}}, 1'b1} << (CURV_FRAC_BITS + 17);
   localparam logic [REM_W-1:0]      BRAKE_REM0 = {{(REM_W-1){1'b0}}, 1'b1} << (CURV_FRAC_BITS + 16);

   logic adv;

   logic [14:0] max_speed_ff;
   logic [23:0] axis_ff;
   logic [23:0] radius_ff;
   logic [16:0] rotate_ff;
   logic [16:0] overlay_ff;
   logic [31:0] mo_ff;

   logic               s1_valid_ff, s1_straight_ff;
   logic signed [31:0] s1_k_ff;
   logic [31:0]        s1_absk_ff;
   logic [31:0]        absk_in;

   logic                   s2_valid_ff, s2_straight_ff;
   logic signed [MAG_W:0]  s2_p_ff;
   logic [MAG_W-1:0]       s2_prod_ff;

   logic                   s3_valid_ff, s3_straight_ff, s3_sat_ff;
   logic signed [MAG_W:0]  s3_num_ff, s3_den_ff;
   logic [MAG_W-1:0]       s3_prod_ff;
   logic signed [MAG_W:0]  num_neg, den_neg;

   logic                   s4_valid_ff, s4_straight_ff, s4_sat_ff, s4_neg_ff;
   logic [MAG_W-1:0]       s4_mnum_ff, s4_mden_ff, s4_prod_ff;

   logic                   s5_valid_ff;
   tag_type                s5_tag_ff;
   logic [MAG_W-1:0]       s5_x_ff, s5_d_ff, s5_prod_ff;
   logic                   first_in;

   logic                   dv_valid;
   tag_type                dv_tag;
   logic [RATIO_W-1:0]     dv_ratio;
   logic [BRAKE_W-1:0]     dv_bq;

   logic                   sa_valid_ff;
   tag_type                sa_tag_ff;
   logic [31:0]            sa_t_ff;
   logic [16:0]            sa_brake_ff;
   logic [63:0]            sa_m;
   logic [16:0]            brake_raw;

   logic                   sb_valid_ff;
   tag_type                sb_tag_ff;
   logic [MAG_OUT_W-1:0]   sb_slow_ff, sb_fast_ff, sb_straight_ff;
   logic [49:0]            slow_sum, fast_sum;
   logic [32:0]            straight_sum;

   logic                   rsp_valid_ff;
   logic signed [15:0]     rsp_left_ff, rsp_right_ff;
   logic [15:0]            slow_field, fast_field;

   // The pipeline moves unless a finished item sits in the last stage behind a full output.
   assign adv            = !sb_valid_ff || !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= 15'd1000;
         axis_ff      <= 24'd32768;
         radius_ff    <= 24'd262144;
         rotate_ff    <= 17'd6554;
         overlay_ff   <= 17'd65536;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_MAX_SPEED: max_speed_ff <= csr_chan.data[14:0];
            REG_AXIS:      axis_ff      <= csr_chan.data;
            REG_RADIUS:    radius_ff    <= csr_chan.data;
            REG_ROTATE:    rotate_ff    <= csr_chan.data[16:0];
            REG_OVERLAY:   overlay_ff   <= csr_chan.data[16:0];
            default: ;
         endcase
      end
   end

   // Product of full speed and overlay; read only at the divider output and in the stages after it.
   always_ff @(posedge clock) begin
      mo_ff <= 32'(max_speed_ff) * 32'(overlay_ff);
   end

   always_comb begin
      absk_in = req_chan.curvature[31] ? (~req_chan.curvature + 32'd1) : req_chan.curvature;
      num_neg = -s3_num_ff;
      den_neg = -s3_den_ff;
      first_in = s4_mnum_ff < s4_mden_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         sa_valid_ff  <= 1'b0;
         sb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= req_chan.valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
            s5_valid_ff <= s4_valid_ff;
            sa_valid_ff <= dv_valid;
            sb_valid_ff <= sa_valid_ff;
         end
         rsp_valid_ff <= (adv && sb_valid_ff) || (rsp_valid_ff && !rsp_chan.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_k_ff        <= req_chan.curvature;
         s1_absk_ff     <= absk_in;
         s1_straight_ff <= absk_in < STRAIGHT_LIMIT[31:0];

         s2_straight_ff <= s1_straight_ff;
         s2_p_ff        <= (MAG_W+1)'(s1_k_ff) * (MAG_W+1)'($signed({1'b0, axis_ff}));
         s2_prod_ff     <= MAG_W'(s1_absk_ff) * MAG_W'(radius_ff);

         s3_straight_ff <= s2_straight_ff;
         s3_num_ff      <= UNIT_FIX - s2_p_ff;
         s3_den_ff      <= UNIT_FIX + s2_p_ff;
         s3_prod_ff     <= s2_prod_ff;
         // A quotient of 1.0 or more saturates, zero product included.
         s3_sat_ff      <= REM_W'(s2_prod_ff) <= BRAKE_REM0;

         s4_straight_ff <= s3_straight_ff;
         s4_sat_ff      <= s3_sat_ff;
         s4_neg_ff      <= s3_num_ff[MAG_W] ^ s3_den_ff[MAG_W];
         s4_mnum_ff     <= s3_num_ff[MAG_W] ? num_neg[MAG_W-1:0] : s3_num_ff[MAG_W-1:0];
         s4_mden_ff     <= s3_den_ff[MAG_W] ? den_neg[MAG_W-1:0] : s3_den_ff[MAG_W-1:0];
         s4_prod_ff     <= s3_prod_ff;

         s5_tag_ff.straight  <= s4_straight_ff;
         s5_tag_ff.neg       <= s4_neg_ff;
         s5_tag_ff.first     <= first_in;
         s5_tag_ff.brake_sat <= s4_sat_ff;
         s5_x_ff             <= first_in ? s4_mnum_ff : s4_mden_ff;
         s5_d_ff             <= first_in ? s4_mden_ff : s4_mnum_ff;
         s5_prod_ff          <= s4_prod_ff;
      end
   end

   c2ws_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s5_valid_ff),
      .in_tag    (s5_tag_ff),
      .in_x      (s5_x_ff),
      .in_d      (s5_d_ff),
      .in_prod   (s5_prod_ff),
      .in_brem   (BRAKE_REM0),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_ratio (dv_ratio),
      .out_bq    (dv_bq)
   );

   always_comb begin
      sa_m         = 64'(mo_ff) * 64'(dv_ratio);
      brake_raw    = dv_tag.brake_sat ? UNITY_Q16 : 17'(dv_bq);
      slow_sum     = 50'(sa_t_ff) * 50'(sa_brake_ff) + (50'd1 << 31);
      fast_sum     = 50'(mo_ff) * 50'(sa_brake_ff) + (50'd1 << 31);
      straight_sum = 33'(mo_ff) + 33'd32768;
      slow_field   = sb_tag_ff.neg ? -16'(sb_slow_ff) : 16'(sb_slow_ff);
      fast_field   = 16'(sb_fast_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_tag_ff   <= dv_tag;
         sa_t_ff     <= sa_m[62:31];
         sa_brake_ff <= (brake_raw < rotate_ff) ? rotate_ff : brake_raw;

         sb_tag_ff      <= sa_tag_ff;
         sb_slow_ff     <= sat_speed(slow_sum[49:32]);
         sb_fast_ff     <= sat_speed(fast_sum[49:32]);
         sb_straight_ff <= sat_speed(18'(straight_sum[32:16]));
      end
      if (adv && sb_valid_ff) begin
         if (sb_tag_ff.straight) begin
            rsp_left_ff  <= $signed(16'(sb_straight_ff));
            rsp_right_ff <= $signed(16'(sb_straight_ff));
         end else if (sb_tag_ff.first) begin
            rsp_left_ff  <= $signed(slow_field);
            rsp_right_ff <= $signed(fast_field);
         end else begin
            rsp_left_ff  <= $signed(fast_field);
            rsp_right_ff <= $signed(slow_field);
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.left_speed  = rsp_left_ff;
   assign rsp_chan.right_speed = rsp_right_ff;

endmodule
`default_nettype wire

### hdl/c2ws_div_pipe.sv
// Pipelined restoring dividers: ratio bit per stage, brake bit in stages 0 to 15.
// Depends on c2ws_pkg for widths and the tag struct.
`default_nettype none
module c2ws_div_pipe (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         enable,
   input  wire logic                         in_valid,
   input  wire c2ws_pkg::tag_type            in_tag,
   input  wire logic [c2ws_pkg::MAG_W-1:0]   in_x,
   input  wire logic [c2ws_pkg::MAG_W-1:0]   in_d,
   input  wire logic [c2ws_pkg::MAG_W-1:0]   in_prod,
   input  wire logic [c2ws_pkg::REM_W-1:0]   in_brem,
   output logic                              out_valid,
   output c2ws_pkg::tag_type                 out_tag,
   output logic [c2ws_pkg::RATIO_W-1:0]      out_ratio,
   output logic [c2ws_pkg::BRAKE_W-1:0]      out_bq
);
   import c2ws_pkg::*;

   logic                 valid_ff [RATIO_STEPS];
   tag_type              tag_ff   [RATIO_STEPS];
   logic [REM_W-1:0]     rem_ff   [RATIO_STEPS];
   logic [MAG_W-1:0]     d_ff     [RATIO_STEPS];
   logic [RATIO_W-1:0]   q_ff     [RATIO_STEPS];
   logic [BRAKE_W-1:0]   bq_ff    [RATIO_STEPS];
   logic [REM_W-1:0]     brem_ff  [BRAKE_STEPS];
   logic [MAG_W-1:0]     prod_ff  [BRAKE_STEPS];

   logic                 valid_src [RATIO_STEPS];
   tag_type              tag_src   [RATIO_STEPS];
   logic [REM_W-1:0]     rem_src   [RATIO_STEPS];
   logic [MAG_W-1:0]     d_src     [RATIO_STEPS];
   logic [RATIO_W-1:0]   q_src     [RATIO_STEPS];
   logic [BRAKE_W-1:0]   bq_src    [RATIO_STEPS];
   logic [REM_W-1:0]     brem_src  [BRAKE_STEPS];
   logic [MAG_W-1:0]     prod_src  [BRAKE_STEPS];

   logic [REM_W-1:0]     rem_in   [RATIO_STEPS];
   logic [RATIO_W-1:0]   q_in     [RATIO_STEPS];
   logic [BRAKE_W-1:0]   bq_in    [RATIO_STEPS];
   logic [REM_W-1:0]     brem_in  [BRAKE_STEPS];
   logic                 r_ge     [RATIO_STEPS];
   logic                 b_ge     [BRAKE_STEPS];
   logic [REM_W-1:0]     b_sh     [BRAKE_STEPS];

   // Stage j takes its operands from stage j-1, stage 0 from the inputs.
   always_comb begin
      valid_src[0] = in_valid;
      tag_src[0]   = in_tag;
      rem_src[0]   = REM_W'(in_x);
      d_src[0]     = in_d;
      q_src[0]     = '0;
      bq_src[0]    = '0;
      brem_src[0]  = in_brem;
      prod_src[0]  = in_prod;
      for (int j = 1; j < RATIO_STEPS; j++) begin
         valid_src[j] = valid_ff[j-1];
         tag_src[j]   = tag_ff[j-1];
         rem_src[j]   = rem_ff[j-1];
         d_src[j]     = d_ff[j-1];
         q_src[j]     = q_ff[j-1];
         bq_src[j]    = bq_ff[j-1];
      end
      for (int j = 1; j < BRAKE_STEPS; j++) begin
         brem_src[j] = brem_ff[j-1];
         prod_src[j] = prod_ff[j-1];
      end
   end

   // Ratio: compare, subtract, then shift the partial remainder.
   always_comb begin
      for (int j = 0; j < RATIO_STEPS; j++) begin
         r_ge[j]   = rem_src[j] >= REM_W'(d_src[j]);
         rem_in[j] = (r_ge[j] ? rem_src[j] - REM_W'(d_src[j]) : rem_src[j]) << 1;
         q_in[j]   = {q_src[j][RATIO_W-2:0], r_ge[j]};
         bq_in[j]  = bq_src[j];
      end
      // Brake quotient: shift in a zero dividend bit, then compare and subtract.
      for (int j = 0; j < BRAKE_STEPS; j++) begin
         b_sh[j]    = brem_src[j] << 1;
         b_ge[j]    = b_sh[j] >= REM_W'(prod_src[j]);
         brem_in[j] = b_ge[j] ? b_sh[j] - REM_W'(prod_src[j]) : b_sh[j];
         bq_in[j]   = {bq_src[j][BRAKE_W-2:0], b_ge[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < RATIO_STEPS; j++) valid_ff[j] <= 1'b0;
      end else if (enable) begin
         for (int j = 0; j < RATIO_STEPS; j++) valid_ff[j] <= valid_src[j];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < RATIO_STEPS; j++) begin
            tag_ff[j] <= tag_src[j];
            rem_ff[j] <= rem_in[j];
            d_ff[j]   <= d_src[j];
            q_ff[j]   <= q_in[j];
            bq_ff[j]  <= bq_in[j];
         end
         for (int j = 0; j < BRAKE_STEPS; j++) begin
            brem_ff[j] <= brem_in[j];
            prod_ff[j] <= prod_src[j];
         end
      end
   end

   assign out_valid = valid_ff[RATIO_STEPS-1];
   assign out_tag   = tag_ff[RATIO_STEPS-1];
   assign out_ratio = q_ff[RATIO_STEPS-1];
   assign out_bq    = bq_ff[RATIO_STEPS-1];

endmodule
`default_nettype wire

### hdl/c2ws_checker.sv
// Port-level checks for curvature_to_wheel_speeds, attached by the bind at the end.
// Depends only on the top level's channel signals.
`default_nettype none
module c2ws_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [15:0] left_speed,
   input wire logic signed [15:0] right_speed
);
   logic [6:0]         pending_ff;
   logic [6:0]         pending_in;
   logic signed [16:0] left_ext, right_ext;
   logic               left_leads, right_leads;

   assign pending_in = pending_ff + 7'(req_valid && req_ready) - 7'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // The full-speed wheel is never slower than the slow one.
   always_comb begin
      left_ext    = 17'(left_speed);
      right_ext   = 17'(right_speed);
      left_leads  = !left_speed[15] && (right_ext <= left_ext) && (-right_ext <= left_ext);
      right_leads = !right_speed[15] && (left_ext <= right_ext) && (-left_ext <= right_ext);
   end

   a_idle_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 7'd0)
      else $error("response beat without an outstanding request");

   a_wheel_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (left_leads || right_leads))
      else $error("slow wheel faster than full-speed wheel");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_speed) && $stable(right_speed))
      else $error("stalled response changed");

endmodule

bind curvature_to_wheel_speeds c2ws_checker u_c2ws_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .left_speed  (rsp_chan.left_speed),
   .right_speed (rsp_chan.right_speed)
);
`default_nettype wire

### test/curvature_to_wheel_speeds_test.sv
// Self-checking testbench for curvature_to_wheel_speeds: directed and random curvatures under
// many register settings, with bursty requests and a stalling response side.
// Depends on c2ws_pkg, the c2ws interfaces and the block's RTL.
`timescale 1ns / 100ps
module curvature_to_wheel_speeds_test;
   import c2ws_pkg::*;

   localparam int CURV_FRAC_BITS = 24;
   localparam logic [63:0] STRAIGHT_LIMIT =
      ((64'd1 << CURV_FRAC_BITS) + 64'd999999) / 64'd1000000;
   localparam longint CURV_ONE = 64'sd1 <<< (CURV_FRAC_BITS + 17);
   localparam logic [63:0] UNIT_RATIO = 64'd1 << 31;

   typedef struct {
      logic [14:0] max_speed;
      logic [23:0] axis;
      logic [23:0] radius;
      logic [16:0] rotate;
      logic [16:0] overlay;
   } wheel_setting_type;

   typedef struct {
      logic signed [31:0] curvature;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
   } wheel_speeds_type;

   logic clock = 1'b0;
   logic reset;

   c2ws_req_if req_bus ();
   c2ws_rsp_if rsp_bus ();
   c2ws_csr_if csr_bus ();

   curvature_to_wheel_speeds #(.CURV_FRAC_BITS(CURV_FRAC_BITS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #1 clock = ~clock;

   wheel_setting_type cur_setting = '{15'd1000, 24'd32768, 24'd262144, 17'd6554, 17'd65536};
   wheel_speeds_type  pending_speeds [$];
   int             burst_left = 0;
   int             curvatures_sent = 0;
   int             speeds_checked = 0;
   int             speed_mismatches = 0;
   int             settings_applied = 1;
   int unsigned    stall_hold = 0;
   int unsigned    stall_mode = 0;
   int unsigned    cycle_count = 0;

   // Wheel magnitude for a Q1.31 ratio and a Q.16 brake factor, saturated.
   function automatic logic [14:0] scaled_wheel_mag(input logic [63:0] ratio,
                                                    input logic [63:0] brake);
      logic [127:0] t;
      t = 128'(cur_setting.max_speed) * 128'(ratio) * 128'(cur_setting.overlay);
      t = t >> 31;
      t = (t * 128'(brake) + (128'd1 << 31)) >> 32;
      return (t > 128'(SPEED_SAT)) ? SPEED_SAT : t[14:0];
   endfunction

   function automatic wheel_speeds_type predict_wheel_speeds(input logic signed [31:0] k);
      wheel_speeds_type   w;
      longint             ks, prod_axis, num_v, den_v;
      logic [63:0]        abs_k, mag_num, mag_den, prod_rad, brake, ratio;
      logic [127:0]       wide_val;
      logic [14:0]        level, slow, fast;
      logic signed [15:0] slow_field;
      logic               neg, first;
      w.curvature = k;
      ks = k;
      abs_k = (ks < 0) ? 64'(-ks) : 64'(ks);
      if (abs_k < STRAIGHT_LIMIT) begin
         wide_val = (128'(cur_setting.max_speed) * 128'(cur_setting.overlay) + 128'd32768) >> 16;
         level = (wide_val > 128'(SPEED_SAT)) ? SPEED_SAT : wide_val[14:0];
         w.left_speed = {1'b0, level};
         w.right_speed = {1'b0, level};
         return w;
      end
      prod_axis = ks * longint'(cur_setting.axis);
      num_v = CURV_ONE - prod_axis;
      den_v = CURV_ONE + prod_axis;
      mag_num = (num_v < 0) ? 64'(-num_v) : 64'(num_v);
      mag_den = (den_v < 0) ? 64'(-den_v) : 64'(den_v);
      neg = (num_v < 0) != (den_v < 0);

      // Braking factor: 1/(|k|*radius) in Q.16, clamped to [rotate, 1.0], lower bound last.
      prod_rad = abs_k * 64'(cur_setting.radius);
      if (prod_rad == 0) begin
         brake = 64'(UNITY_Q16);
      end else begin
         brake = (64'd1 << (CURV_FRAC_BITS + 32)) / prod_rad;
         if (brake > 64'(UNITY_Q16)) brake = 64'(UNITY_Q16);
      end
      if (brake < 64'(cur_setting.rotate)) brake = 64'(cur_setting.rotate);

      first = mag_num < mag_den;
      wide_val = first ? (128'(mag_num) << 31) / 128'(mag_den)
                       : (128'(mag_den) << 31) / 128'(mag_num);
      ratio = wide_val[63:0];
      slow = scaled_wheel_mag(ratio, brake);
      fast = scaled_wheel_mag(UNIT_RATIO, brake);
      slow_field = neg ? -$signed({1'b0, slow}) : $signed({1'b0, slow});
      // The slow wheel lands on the left after the swap when |num| < |den|.
      if (first) begin
         w.left_speed = slow_field;
         w.right_speed = {1'b0, fast};
      end else begin
         w.left_speed = {1'b0, fast};
         w.right_speed = slow_field;
      end
      return w;
   endfunction

   function automatic logic [23:0] pick_register(input int unsigned lo, hi, dflt, wide);
      int unsigned v;
      case ($urandom_range(7, 0))
         0: v = lo;
         1: v = hi;
         2: v = dflt;
         3: v = $urandom_range(wide, lo);
         4, 5: v = $urandom_range(hi, lo) >> $urandom_range(23, 0);
         default: v = $urandom_range(hi, lo);
      endcase
      return 24'((v < lo) ? lo : v);
   endfunction

   function automatic wheel_setting_type random_setting();
      wheel_setting_type s;
      s.max_speed = 15'(pick_register(0, 32767, 1000, 32767));
      s.axis      = pick_register(1, 16777215, 32768, 16777215);
      s.radius    = pick_register(1, 16777215, 262144, 16777215);
      s.rotate    = 17'(pick_register(0, 65536, 6554, 131071));
      s.overlay   = 17'(pick_register(0, 65536, 65536, 131071));
      return s;
   endfunction

   function automatic logic signed [31:0] random_curvature();
      logic [63:0]        crossing;
      logic signed [31:0] k;
      case ($urandom_range(7, 0))
         0, 1: k = $urandom();
         2: k = int'($urandom_range(48, 0)) - 24;
         3, 4, 5: k = $urandom() >> $urandom_range(31, 0);
         default: begin
            // Aim near k*axis/2 = 1, where num or den changes sign.
            if (cur_setting.axis == 0) begin
               k = $urandom();
            end else begin
               crossing = (64'd1 << (CURV_FRAC_BITS + 17)) / 64'(cur_setting.axis);
               if (crossing > 64'h7FFF_FF00) crossing = 64'h7FFF_FF00;
               k = 32'(crossing) + int'($urandom_range(64, 0)) - 32;
            end
         end
      endcase
      if ($urandom_range(1, 0) == 1) k = -k;
      return k;
   endfunction

   task automatic flag_speed_error(input string what);
      speed_mismatches++;
      if (speed_mismatches <= 10) $display("[%0t] %s", $time, what);
   endtask

   // One curvature beat; requests come in bursts separated by short random gaps.
   task automatic send_curvature(input logic signed [31:0] k);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
         burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(120, 40)
                                                  : $urandom_range(12, 1);
      end
      req_bus.valid <= 1'b1;
      req_bus.curvature <= k;
      do @(posedge clock); while (!req_bus.ready);
      pending_speeds.push_back(predict_wheel_speeds(k));
      curvatures_sent++;
      burst_left--;
   endtask

   task automatic drain_speeds();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_speeds.size() != 0);
   endtask

   // Registers change only with the pipeline empty; valid stays high across the five beats.
   task automatic apply_setting(input wheel_setting_type s);
      csr_index_type idx [5];
      logic [23:0]   val [5];
      idx = '{REG_MAX_SPEED, REG_AXIS, REG_RADIUS, REG_ROTATE, REG_OVERLAY};
      val = '{24'(s.max_speed), s.axis, s.radius, 24'(s.rotate), 24'(s.overlay)};
      drain_speeds();
      for (int i = 0; i < 5; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx[i];
         csr_bus.data <= val[i];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      cur_setting = s;
      settings_applied++;
   endtask

   task automatic test_reset_defaults();
      logic signed [31:0] probe [14];
      probe = '{0, 16, -16, 17, -17, 32'sh7FFFFFFF, 32'sh80000000, 67108864, -67108864,
                16777216, 1048576, 32'sh55555555, 32'shAAAAAAAA, -33554432};
      foreach (probe[i]) send_curvature(probe[i]);
   endtask

   // Zero axis (equal magnitudes), zero radius, oversized factors, rotate factor above one.
   task automatic test_special_cases();
      wheel_setting_type  corner [4];
      logic signed [31:0] probe [4][3];
      corner = '{'{15'd1000, 24'd0, 24'd262144, 17'd6554, 17'd65536},
                 '{15'd1000, 24'd32768, 24'd0, 17'd6554, 17'd65536},
                 '{15'd32767, 24'd32768, 24'd262144, 17'd131071, 17'd131071},
                 '{15'd20000, 24'd32768, 24'd262144, 17'd98304, 17'd40000}};
      probe = '{'{16777216, -4194304, 268435456},
                '{4194304, -33554432, 134217728},
                '{0, 8388608, -67108864},
                '{1048576, -16777216, 33554432}};
      for (int i = 0; i < 4; i++) begin
         apply_setting(corner[i]);
         for (int j = 0; j < 3; j++) send_curvature(probe[i][j]);
      end
   endtask

   task automatic test_register_extremes();
      wheel_setting_type bound [2];
      bound = '{'{15'd0, 24'd1, 24'd1, 17'd0, 17'd0},
                '{15'd32767, 24'hFFFFFF, 24'hFFFFFF, 17'd65536, 17'd65536}};
      foreach (bound[i]) begin
         apply_setting(bound[i]);
         repeat (50) send_curvature(random_curvature());
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 10; phase++) begin
         apply_setting(random_setting());
         for (int n = 0; n < 145; n++) begin
            // Once, let the whole pipeline empty out mid-phase.
            if (phase == 4 && n == 70) drain_speeds();
            send_curvature(random_curvature());
         end
      end
   endtask

   // Response stalls follow a mode that is redrawn at random after a random hold.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_hold == 0) begin
         stall_mode <= $urandom_range(3, 0);
         stall_hold <= $urandom_range(300, 20);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(3, 0) != 0);
         2: rsp_bus.ready <= ($urandom_range(3, 0) == 0);
         default: rsp_bus.ready <= (cycle_count[4:2] != 3'd0);
      endcase
   end

   always @(posedge clock) begin : check_speeds
      wheel_speeds_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         speeds_checked++;
         if (pending_speeds.size() == 0) begin
            flag_speed_error($sformatf("unexpected beat left=%0d right=%0d",
                                       rsp_bus.left_speed, rsp_bus.right_speed));
         end else begin
            want = pending_speeds.pop_front();
            if (rsp_bus.left_speed !== want.left_speed)
               flag_speed_error($sformatf("k=%0d left_speed expected %0d got %0d",
                                          want.curvature, want.left_speed, rsp_bus.left_speed));
            if (rsp_bus.right_speed !== want.right_speed)
               flag_speed_error($sformatf("k=%0d right_speed expected %0d got %0d",
                                          want.curvature, want.right_speed,
                                          rsp_bus.right_speed));
         end
      end
   end

   initial begin : watchdog
      #1_000_000;
      $display("curvature_to_wheel_speeds verification failed");
      $finish;
   end

   initial begin : run_tests
      req_bus.valid <= 1'b0;
      req_bus.curvature <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_MAX_SPEED;
      csr_bus.data <= '0;
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_special_cases();
      test_register_extremes();
      test_random_traffic();

      drain_speeds();
      repeat (64) @(posedge clock);
      $display("Sent %0d curvature beats under %0d register settings, compared %0d speed beats.",
               curvatures_sent, settings_applied, speeds_checked);
      $display("Speed mismatches: %0d, results still outstanding: %0d.",
               speed_mismatches, pending_speeds.size());
      if (speed_mismatches == 0 && pending_speeds.size() == 0) begin
         $display("curvature_to_wheel_speeds verification clean");
      end else begin
         $display("curvature_to_wheel_speeds verification failed");
      end
      $finish;
   end

endmodule

### curvature_to_wheel_speeds.f
hdl/c2ws_pkg.sv
hdl/c2ws_if.sv
hdl/c2ws_div_pipe.sv
hdl/curvature_to_wheel_speeds.sv
hdl/c2ws_checker.sv
test/curvature_to_wheel_speeds_test.sv
